FILE: hdl/fmc_pkg.sv
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared types and constants of the float / minifloat converter.
// ----------------------------------------------------------------------------
package fmc_pkg;

	localparam int WORD_W   = 32;
	localparam int MANT_W   = 23;
	localparam int EXPF_W   = 8;
	localparam int MAG_W    = 31;
	localparam int EXPW_W   = 4;
	localparam int MANW_W   = 5;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int BIAS     = 127;

	localparam int EXP_MIN   = 2;
	localparam int EXP_MAX   = 8;
	localparam int MAN_MIN   = 2;
	localparam int MAN_MAX   = 23;
	localparam int EXP_RESET = 5;
	localparam int MAN_RESET = 10;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXP_WIDTH = 1'b0,
		REG_MAN_WIDTH = 1'b1
	} cfg_reg_t;

	// stage 1: captured word, clamped widths and saturation limits
	typedef struct packed {
		mode_t              mode;
		logic [WORD_W-1:0]  value;
		logic [EXPW_W-1:0]  e;
		logic [MANW_W-1:0]  m;
		logic [MAG_W-1:0]   hi_mag;
		logic [MAG_W-1:0]   lo_mag;
	} s1_t;

	// stage 2: compare outcomes and unpacked fields for both directions
	typedef struct packed {
		mode_t              mode;
		logic [EXPW_W-1:0]  e;
		logic [MANW_W-1:0]  m;
		logic               sgn;
		logic               ge_hi;
		logic               le_lo;
		logic               neg_x;
		logic [6:0]         absx;
		logic [MANT_W-1:0]  mant_x;
		logic               dsign;
		logic               dneg;
		logic [6:0]         dmag;
		logic [MANT_W-1:0]  dmant;
	} s2_t;

endpackage

FILE: hdl/fmc_if.sv
// ----------------------------------------------------------------------------
// fmc_in_if / fmc_out_if
// Valid/ready channels of the converter: request word in, result word out.
// ----------------------------------------------------------------------------
interface fmc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [fmc_pkg::WORD_W-1:0]  value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

interface fmc_out_if;
	logic                        valid;
	logic                        ready;
	logic [fmc_pkg::WORD_W-1:0]  result;

	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

FILE: hdl/fmc_front.sv
// ----------------------------------------------------------------------------
// fmc_front
// Stage 1: clamp the width registers, build the saturation limits, capture.
// ----------------------------------------------------------------------------
module fmc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fmc_pkg::EXPW_W-1:0]    exp_width,
	input  logic [fmc_pkg::MANW_W-1:0]    man_width,
	fmc_in_if.sink                        item_in,
	output logic                          valid_s1,
	output fmc_pkg::s1_t                  stage1_s1,
	input  logic                          next_ready
);

	logic [fmc_pkg::EXPW_W-1:0]  e;
	logic [fmc_pkg::MANW_W-1:0]  m;
	logic [2:0]                  b;
	logic [fmc_pkg::EXPF_W-1:0]  pow_b;
	logic [fmc_pkg::EXPF_W-1:0]  hi_biased;
	logic [fmc_pkg::EXPF_W-1:0]  lo_biased;
	logic [fmc_pkg::MANT_W-1:0]  hi_mant;
	logic [fmc_pkg::MANT_W-1:0]  lo_mant;
	fmc_pkg::s1_t                next_s1;

	always_comb begin
		if (exp_width < fmc_pkg::EXPW_W'(fmc_pkg::EXP_MIN)) begin
			e = fmc_pkg::EXPW_W'(fmc_pkg::EXP_MIN);
		end else if (exp_width > fmc_pkg::EXPW_W'(fmc_pkg::EXP_MAX)) begin
			e = fmc_pkg::EXPW_W'(fmc_pkg::EXP_MAX);
		end else begin
			e = exp_width;
		end
		if (man_width < fmc_pkg::MANW_W'(fmc_pkg::MAN_MIN)) begin
			m = fmc_pkg::MANW_W'(fmc_pkg::MAN_MIN);
		end else if (man_width > fmc_pkg::MANW_W'(fmc_pkg::MAN_MAX)) begin
			m = fmc_pkg::MANW_W'(fmc_pkg::MAN_MAX);
		end else begin
			m = man_width;
		end
	end

	// largest code: exponent +(2^b - 1), mantissa all ones
	// smallest code: exponent -(2^b - 2), mantissa lsb only
	assign b         = 3'(e - 4'd1);
	assign pow_b     = 8'd1 << b;
	assign hi_biased = 8'(fmc_pkg::BIAS - 1) + pow_b;
	assign lo_biased = 8'(fmc_pkg::BIAS + 2) - pow_b;
	assign hi_mant   = ~({fmc_pkg::MANT_W{1'b1}} >> m);
	assign lo_mant   = {1'b1, {(fmc_pkg::MANT_W-1){1'b0}}} >> (m - 5'd1);

	always_comb begin
		next_s1.mode   = fmc_pkg::mode_t'(item_in.mode);
		next_s1.value  = item_in.value;
		next_s1.e      = e;
		next_s1.m      = m;
		next_s1.hi_mag = {hi_biased, hi_mant};
		next_s1.lo_mag = {lo_biased, lo_mant};
	end

	assign item_in.ready = !valid_s1 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			stage1_s1 <= next_s1;
		end
	end

endmodule

FILE: hdl/fmc_core.sv
// ----------------------------------------------------------------------------
// fmc_core
// Stage 2: magnitude compares and field extraction for encode and decode.
// ----------------------------------------------------------------------------
module fmc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  fmc_pkg::s1_t  stage1_s1,
	output logic          this_ready,
	output logic          valid_s2,
	output fmc_pkg::s2_t  stage2_s2,
	input  logic          next_ready
);

	logic [fmc_pkg::MAG_W-1:0]   mag;
	logic [fmc_pkg::EXPF_W-1:0]  field;
	logic [fmc_pkg::EXPF_W-1:0]  absx8;
	logic [2:0]                  b;
	logic [5:0]                  em;
	logic [5:0]                  em_lo;
	logic [fmc_pkg::WORD_W-1:0]  shifted;
	logic [6:0]                  mask_b;
	logic [fmc_pkg::MANT_W-1:0]  mask_m;
	fmc_pkg::s2_t                next_s2;

	assign mag    = stage1_s1.value[fmc_pkg::MAG_W-1:0];
	assign field  = mag[fmc_pkg::MAG_W-1:fmc_pkg::MANT_W];
	assign b      = 3'(stage1_s1.e - 4'd1);
	assign em     = {2'b00, stage1_s1.e} + {1'b0, stage1_s1.m};
	assign em_lo  = em - 6'd1;
	assign shifted = stage1_s1.value >> stage1_s1.m;
	assign mask_b = 7'((8'd1 << b) - 8'd1);
	assign mask_m = ~({fmc_pkg::MANT_W{1'b1}} << stage1_s1.m);
	assign absx8  = (field < 8'(fmc_pkg::BIAS)) ? (8'(fmc_pkg::BIAS) - field)
	                                            : (field - 8'(fmc_pkg::BIAS));

	always_comb begin
		next_s2.mode   = stage1_s1.mode;
		next_s2.e      = stage1_s1.e;
		next_s2.m      = stage1_s1.m;
		// negative zero packs as positive
		next_s2.sgn    = stage1_s1.value[fmc_pkg::WORD_W-1] && (mag != '0);
		next_s2.ge_hi  = mag >= stage1_s1.hi_mag;
		next_s2.le_lo  = mag <= stage1_s1.lo_mag;
		next_s2.neg_x  = field < 8'(fmc_pkg::BIAS);
		next_s2.absx   = absx8[6:0];
		next_s2.mant_x = mag[fmc_pkg::MANT_W-1:0] >> (5'd23 - stage1_s1.m);
		next_s2.dsign  = stage1_s1.value[em[4:0]];
		next_s2.dneg   = stage1_s1.value[em_lo[4:0]];
		next_s2.dmag   = shifted[6:0] & mask_b;
		next_s2.dmant  = stage1_s1.value[fmc_pkg::MANT_W-1:0] & mask_m;
	end

	assign this_ready = !valid_s2 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (this_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && this_ready) begin
			stage2_s2 <= next_s2;
		end
	end

endmodule

FILE: hdl/fmc_pack.sv
// ----------------------------------------------------------------------------
// fmc_pack
// Stage 3: assemble the packed code or the IEEE word into the output register.
// ----------------------------------------------------------------------------
module fmc_pack (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s2,
	input  fmc_pkg::s2_t  stage2_s2,
	output logic          this_ready,
	fmc_out_if.source     item_out
);

	logic                        valid_s3;
	logic [fmc_pkg::WORD_W-1:0]  result_s3;
	logic [2:0]                  b;
	logic [fmc_pkg::EXPF_W-1:0]  pow_b;
	logic [5:0]                  em;
	logic [fmc_pkg::MANT_W-1:0]  mask_m;
	logic [fmc_pkg::EXPF_W-1:0]  biased;
	logic [fmc_pkg::WORD_W-1:0]  dec_word;
	logic [fmc_pkg::EXPF_W-1:0]  exp8;
	logic [fmc_pkg::MANT_W-1:0]  mant;
	logic [fmc_pkg::WORD_W-1:0]  enc_word;
	logic [fmc_pkg::WORD_W-1:0]  next_result;

	assign b      = 3'(stage2_s2.e - 4'd1);
	assign pow_b  = 8'd1 << b;
	assign em     = {2'b00, stage2_s2.e} + {1'b0, stage2_s2.m};
	assign mask_m = ~({fmc_pkg::MANT_W{1'b1}} << stage2_s2.m);

	assign biased = stage2_s2.dneg ? (8'(fmc_pkg::BIAS) - {1'b0, stage2_s2.dmag})
	                               : (8'(fmc_pkg::BIAS) + {1'b0, stage2_s2.dmag});
	assign dec_word = {stage2_s2.dsign, biased,
	                   stage2_s2.dmant << (5'd23 - stage2_s2.m)};

	always_comb begin
		if (stage2_s2.ge_hi) begin
			exp8 = pow_b - 8'd1;
			mant = mask_m;
		end else if (stage2_s2.le_lo) begin
			// wraps to the right field for the widest exponent
			exp8 = (8'd1 << stage2_s2.e) - 8'd2;
			mant = 23'd1;
		end else begin
			exp8 = ({7'd0, stage2_s2.neg_x} << b) | ({1'b0, stage2_s2.absx} & (pow_b - 8'd1));
			mant = stage2_s2.mant_x;
		end
	end

	assign enc_word = ({24'd0, exp8} << stage2_s2.m) | {9'd0, mant}
	                | ({31'd0, stage2_s2.sgn} << em);

	assign next_result = (stage2_s2.mode == fmc_pkg::MODE_DECODE) ? dec_word : enc_word;

	assign this_ready      = !valid_s3 || item_out.ready;
	assign item_out.valid  = valid_s3;
	assign item_out.result = result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (this_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && this_ready) begin
			result_s3 <= next_result;
		end
	end

endmodule

FILE: hdl/float_minifloat_converter_unit.sv
// ----------------------------------------------------------------------------
// float_minifloat_converter_unit
// Converts IEEE single words to packed minifloat codes and back.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output is not stalled and returns
// one result per transaction, in order: the clamp and limit stage, the compare
// and field-extraction stage, and the output register each hold one item. Each
// stage passes its item on whenever the stage after it is empty or moving, so
// bubbles close up while the output is stalled. Encode truncates the mantissa
// and saturates to the largest or smallest code; decode ignores code bits above
// the sign. Write exponent_width (index 0) and mantissa_width (index 1) only
// while no transaction is in flight; out-of-range widths are clamped.
module float_minifloat_converter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	fmc_in_if.sink                          item_in,
	fmc_out_if.source                       item_out,
	input  logic                            cfg_we,
	input  logic [fmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fmc_pkg::CFG_W-1:0]       cfg_data
);

	logic [fmc_pkg::EXPW_W-1:0]  exp_width_q;
	logic [fmc_pkg::MANW_W-1:0]  man_width_q;
	logic                        valid_s1;
	fmc_pkg::s1_t                stage1_s1;
	logic                        core_ready;
	logic                        valid_s2;
	fmc_pkg::s2_t                stage2_s2;
	logic                        pack_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_width_q <= fmc_pkg::EXPW_W'(fmc_pkg::EXP_RESET);
			man_width_q <= fmc_pkg::MANW_W'(fmc_pkg::MAN_RESET);
		end else if (cfg_we) begin
			case (fmc_pkg::cfg_reg_t'(cfg_index))
				fmc_pkg::REG_EXP_WIDTH: begin
					exp_width_q <= cfg_data[fmc_pkg::EXPW_W-1:0];
				end
				fmc_pkg::REG_MAN_WIDTH: begin
					man_width_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	fmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.exp_width  (exp_width_q),
		.man_width  (man_width_q),
		.item_in    (item_in),
		.valid_s1   (valid_s1),
		.stage1_s1  (stage1_s1),
		.next_ready (core_ready)
	);

	fmc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.stage1_s1  (stage1_s1),
		.this_ready (core_ready),
		.valid_s2   (valid_s2),
		.stage2_s2  (stage2_s2),
		.next_ready (pack_ready)
	);

	fmc_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.stage2_s2  (stage2_s2),
		.this_ready (pack_ready),
		.item_out   (item_out)
	);

`ifndef SYNTH
	a_limits_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (stage1_s1.hi_mag > stage1_s1.lo_mag))
		else $error("saturation limits out of order");

	a_clamp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(stage2_s2.ge_hi && stage2_s2.le_lo))
		else $error("word flagged both above and below the limits");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(item_in.valid && item_in.ready) |=> valid_s1)
		else $error("accepted transaction not held in stage 1");

	a_stage2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !pack_ready) |=> (valid_s2 && $stable(stage2_s2)))
		else $error("stage 2 changed while stalled");
`endif

endmodule
